>>> sv/tws_pkg.sv
// Shared types, constants and state encoding for the timing wheel scheduler.
package tws_pkg;

    localparam int unsigned SLOTS_DEF         = 64;
    localparam int unsigned SLOT_DEPTH_DEF    = 8;
    localparam int unsigned PENDING_DEPTH_DEF = 16;

    localparam logic [15:0] TICK_PERIOD_RST = 16'd50;

    localparam logic       MODE_SCHED = 1'b0;
    localparam logic       MODE_TICK  = 1'b1;

    localparam logic [1:0] ST_FIRED     = 2'd0;
    localparam logic [1:0] ST_LATE      = 2'd1;
    localparam logic [1:0] ST_SLOT_FULL = 2'd2;
    localparam logic [1:0] ST_PEND_FULL = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] event_id;
        logic [31:0] time_value;
    } t_in_word;

    typedef struct packed {
        logic [15:0] event_id_res;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PFULL,
        S_FRD,
        S_FWAIT,
        S_SRD,
        S_SEMIT,
        S_PCHK,
        S_PSEL,
        S_PDUE,
        S_DIV,
        S_DRD,
        S_DWAIT,
        S_DFULL,
        S_FINISH
    } t_state;

endpackage

>>> sv/tws_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module tws_div import tws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [16:0] r_rem;
    logic [31:0] r_q;
    logic [15:0] r_div;
    logic        r_done;

    logic [16:0] trial;
    logic        fits;

    assign trial = {r_rem[15:0], r_q[31]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_q   <= {r_q[30:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> sv/timing_wheel_scheduler_core.sv
// Top level of the timing wheel scheduler: sequencer, wheel memories and output stage.
// A schedule word is queued without stalling; with the pending queue full it stalls
// input and gives one result. A tick emits the fired slot's entries, then each pending
// entry: due ones are emitted, future ones pass through the 32-step divider and are
// stored in their slot (or reported when it is full); output stalls can hold any emit.
// Input is stalled for the whole tick; one item is worked on at a time.
// Synchronous active-low reset clears the sequencer, fill valid bits and pending fill count.
module timing_wheel_scheduler_core import tws_pkg::*; #(
    parameter int unsigned SLOTS         = SLOTS_DEF,
    parameter int unsigned SLOT_DEPTH    = SLOT_DEPTH_DEF,
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    // Slot and entry widths. A slot's entries sit at {slot, entry} in the store.
    localparam int unsigned SLOT_W  = $clog2(SLOTS);
    localparam int unsigned IDX_W   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(SLOT_DEPTH + 1);
    localparam int unsigned PI_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned PF_W    = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned SA_W    = SLOT_W + IDX_W;
    localparam int unsigned STORE_N = SLOTS << IDX_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  SD_CNT    = CNT_W'(SLOT_DEPTH);
    localparam logic [PF_W-1:0]   PD_CNT    = PF_W'(PENDING_DEPTH);

    t_state r_state, n_state;

    logic [15:0]       r_period;
    logic [15:0]       period_eff;
    t_in_word          r_word;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] cur_nxt;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic [PF_W-1:0]   r_pfill;
    logic [PF_W-1:0]   r_pidx;
    logic [15:0]       r_pid;
    logic [31:0]       r_ptime;
    logic [SLOT_W-1:0] r_dst;

    // Pending queue: small register file, written at the fill count.
    logic [15:0] r_pq_id   [PENDING_DEPTH];
    logic [31:0] r_pq_time [PENDING_DEPTH];

    // Fill counts per slot: a memory with one valid bit per slot so reset is instant.
    logic [CNT_W-1:0] fill_mem [SLOTS];
    logic [SLOTS-1:0] r_fvalid;
    logic [CNT_W-1:0] r_fill_q;
    logic             r_fill_qv;
    logic [CNT_W-1:0] fill_val;

    // Event handle store for all slots.
    logic [15:0] store_mem [STORE_N];
    logic [15:0] r_store_q;

    // Results wait one step in a hold register so the final one can carry the last flag.
    logic        r_hold_v;
    logic [15:0] r_hold_id;
    logic [1:0]  r_hold_st;
    logic        r_out_v;
    t_out_word   r_out;

    // Control from the sequencer.
    logic              emit;
    logic [15:0]       emit_id;
    logic [1:0]        emit_st;
    logic              emit_ok;
    logic              out_free;
    logic              fin_push;
    logic              in_acc;
    logic              pend_we;
    logic [SLOT_W-1:0] fill_ra;
    logic              fill_we;
    logic [SLOT_W-1:0] fill_wa;
    logic [CNT_W-1:0]  fill_wd;
    logic [SA_W-1:0]   store_ra;
    logic              store_we;
    logic [SA_W-1:0]   store_wa;
    logic              idx_inc;
    logic              pidx_inc;
    logic              div_start;

    logic              div_done;
    logic [31:0]       div_quot;
    logic [SLOT_W-1:0] slot_dist;
    logic [SLOT_W:0]   dst_sum;
    logic [SLOT_W-1:0] dst_nxt;
    logic [31:0]       gap;

    assign period_eff = (r_period == 16'd0) ? 16'd1 : r_period;
    assign cur_nxt    = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
    assign fill_val   = r_fill_qv ? r_fill_q : '0;
    assign out_free   = !r_out_v || !i_out_stall;
    assign emit_ok    = !r_hold_v || out_free;
    assign gap        = r_word.time_value - r_ptime;

    // Slot distance saturates at SLOTS-1; the sum stays below twice SLOTS.
    assign slot_dist = (div_quot > 32'(SLOTS - 1)) ? LAST_SLOT : div_quot[SLOT_W-1:0];
    assign dst_sum   = {1'b0, r_cur} + (SLOT_W+1)'(1) + {1'b0, slot_dist};
    assign dst_nxt   = (dst_sum >= (SLOT_W+1)'(SLOTS)) ?
                       SLOT_W'(dst_sum - (SLOT_W+1)'(SLOTS)) : dst_sum[SLOT_W-1:0];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    tws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_ptime - r_word.time_value),
        .i_divisor  (period_eff),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        emit_id   = r_pid;
        emit_st   = ST_FIRED;
        fin_push  = 1'b0;
        pend_we   = 1'b0;
        fill_ra   = r_cur;
        fill_we   = 1'b0;
        fill_wa   = r_cur;
        fill_wd   = '0;
        store_ra  = {r_cur, r_idx[IDX_W-1:0]};
        store_we  = 1'b0;
        store_wa  = {r_dst, fill_val[IDX_W-1:0]};
        idx_inc   = 1'b0;
        pidx_inc  = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.mode == MODE_TICK) begin
                        n_state = S_FRD;
                    end else if (r_pfill == PD_CNT) begin
                        n_state = S_PFULL;
                    end else begin
                        pend_we = 1'b1;
                    end
                end
            end
            S_PFULL: begin
                emit    = 1'b1;
                emit_id = r_word.event_id;
                emit_st = ST_PEND_FULL;
                if (emit_ok) begin
                    n_state = S_FINISH;
                end
            end
            S_FRD: begin
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                fill_we = 1'b1;
                n_state = S_SRD;
            end
            S_SRD: begin
                n_state = (r_idx < r_cnt) ? S_SEMIT : S_PCHK;
            end
            S_SEMIT: begin
                emit    = 1'b1;
                emit_id = r_store_q;
                if (emit_ok) begin
                    idx_inc = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_PCHK: begin
                n_state = (r_pidx == r_pfill) ? S_FINISH : S_PSEL;
            end
            S_PSEL: begin
                if (r_ptime < r_word.time_value) begin
                    n_state = S_PDUE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_PDUE: begin
                emit    = 1'b1;
                emit_st = (gap > {16'd0, period_eff}) ? ST_LATE : ST_FIRED;
                if (emit_ok) begin
                    pidx_inc = 1'b1;
                    n_state  = S_PCHK;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DRD;
                end
            end
            S_DRD: begin
                fill_ra = r_dst;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (fill_val >= SD_CNT) begin
                    n_state = S_DFULL;
                end else begin
                    store_we = 1'b1;
                    fill_we  = 1'b1;
                    fill_wa  = r_dst;
                    fill_wd  = fill_val + 1'b1;
                    pidx_inc = 1'b1;
                    n_state  = S_PCHK;
                end
            end
            S_DFULL: begin
                emit    = 1'b1;
                emit_st = ST_SLOT_FULL;
                if (emit_ok) begin
                    pidx_inc = 1'b1;
                    n_state  = S_PCHK;
                end
            end
            S_FINISH: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    fin_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: period, slot pointer, counters and fill valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= TICK_PERIOD_RST;
            r_cur    <= LAST_SLOT;
            r_pfill  <= '0;
            r_fvalid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (in_acc && i_in_word.mode == MODE_TICK) begin
                r_cur <= cur_nxt;
            end
            if (pend_we) begin
                r_pfill <= r_pfill + 1'b1;
            end else if (r_state == S_PCHK && r_pidx == r_pfill) begin
                r_pfill <= '0;
            end
            if (fill_we) begin
                r_fvalid[fill_wa] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_in_word;
        end
        if (pend_we) begin
            r_pq_id[r_pfill[PI_W-1:0]]   <= i_in_word.event_id;
            r_pq_time[r_pfill[PI_W-1:0]] <= i_in_word.time_value;
        end
        if (r_state == S_FWAIT) begin
            r_cnt <= fill_val;
            r_idx <= '0;
        end else if (idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == S_SRD) begin
            r_pidx <= '0;
        end else if (pidx_inc) begin
            r_pidx <= r_pidx + 1'b1;
        end
        if (r_state == S_PCHK) begin
            r_pid   <= r_pq_id[r_pidx[PI_W-1:0]];
            r_ptime <= r_pq_time[r_pidx[PI_W-1:0]];
        end
        if (div_done) begin
            r_dst <= dst_nxt;
        end
    end

    // Fill count memory, registered read.
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        r_fill_q  <= fill_mem[fill_ra];
        r_fill_qv <= r_fvalid[fill_ra];
    end

    // Handle store memory, registered read.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[store_wa] <= r_pid;
        end
        r_store_q <= store_mem[store_ra];
    end

    // Output stage. A new result pushes the held one out with last clear;
    // at the end of the item the held one leaves with last set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (emit && emit_ok) begin
                r_hold_v <= 1'b1;
                if (r_hold_v) begin
                    r_out_v <= 1'b1;
                end else if (!i_out_stall) begin
                    r_out_v <= 1'b0;
                end
            end else if (fin_push) begin
                r_hold_v <= 1'b0;
                r_out_v  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && emit_ok) begin
            r_hold_id <= emit_id;
            r_hold_st <= emit_st;
            if (r_hold_v) begin
                r_out <= '{event_id_res: r_hold_id, status: r_hold_st, last: 1'b0};
            end
        end else if (fin_push) begin
            r_out <= '{event_id_res: r_hold_id, status: r_hold_st, last: 1'b1};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    a_pfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pfill <= PD_CNT)
        else $error("pending fill count above queue depth");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while an item is in progress");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_push |=> (o_out_valid && o_out_word.last))
        else $error("final result did not leave with last set");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held result left behind at end of item");

endmodule
